/* hdl/g6d_pkg.sv */
`default_nettype none
package g6d_pkg;

  // limits and sizes
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int QUEUE_DEPTH_DEF  = 4;
  localparam int VERTEX_W         = 10;
  localparam int COUNT_W          = 36;

  // character codes
  localparam logic [7:0] BIAS         = 8'd63;
  localparam logic [7:0] CHAR_SPARSE  = 8'h3A;
  localparam logic [7:0] CHAR_DIGRAPH = 8'h26;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [5:0] ESCAPE       = 6'd63;

  // size header progress codes
  localparam logic [3:0] HDR_BODY  = 4'd0;
  localparam logic [3:0] HDR_FIRST = 4'd15;
  localparam logic [3:0] HDR_ESC   = 4'd14;
  localparam logic [3:0] HDR_LONG  = 4'd6;
  localparam logic [3:0] HDR_SHORT = 4'd2;

  // body bit position of the first bit of a group
  localparam logic [2:0] BIT_TOP = 3'd5;

  typedef enum logic [1:0] {
    FMT_G6 = 2'd0,
    FMT_S6 = 2'd1,
    FMT_D6 = 2'd2
  } fmt_t;

  // character class decided at the front
  typedef enum logic [3:0] {
    CLS_START_G6 = 4'b0001,
    CLS_START_S6 = 4'b0010,
    CLS_START_D6 = 4'b0100,
    CLS_CONT     = 4'b1000
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [5:0] grp;
    logic       eol;
  } cmd_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q2b_t;

endpackage
`default_nettype wire

/* hdl/graph6_string_edge_decoder_unit.sv */
// results: a header result is registered in the queue and then in the output register; a body
// edge may wait in the held result between them, until the next edge or the end of the word
// flow: the back end takes a header or control word whole and walks a body word one bit per
// cycle unless the output stalls or a held result waits; a flush step follows a word whose
// last bit and an earlier bit both give an edge; g6d_back holds this bit-serial decode step
// reset: synchronous, active low; clears the queue, decoder state and output valid
`default_nettype none
module graph6_string_edge_decoder_unit #(
  parameter int MAX_VERTICES = g6d_pkg::MAX_VERTICES_DEF,
  parameter int QUEUE_DEPTH  = g6d_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // character words
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_starts_string,
  // edge words
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [9:0]      out_first_vertex,
  output logic [9:0]      out_second_vertex,
  output logic            out_size_error,
  output logic            out_last_of_run
);

  // front: classify start characters, bias-strip the six-bit group
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  g6d_pkg::cmd_t f_cmd;
  g6d_pkg::q2b_t q_head;

  g6d_front u_front (
    .in_valid         (in_valid),
    .in_char_code     (in_char_code),
    .in_starts_string (in_starts_string),
    .q_full           (q_full),
    .in_stall         (in_stall),
    .push             (q_push),
    .cmd              (f_cmd)
  );

  // short queue so input acceptance keeps going while the back end walks body bits
  g6d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (f_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .head     (q_head)
  );

  // back: header parse, bit-serial body decode, result hold and output register
  g6d_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (q_head),
    .pop               (q_pop),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_first_vertex  (out_first_vertex),
    .out_second_vertex (out_second_vertex),
    .out_size_error    (out_size_error),
    .out_last_of_run   (out_last_of_run)
  );

endmodule
`default_nettype wire

/* hdl/g6d_front.sv */
`default_nettype none
module g6d_front (
  input  wire logic          in_valid,
  input  wire logic [7:0]    in_char_code,
  input  wire logic          in_starts_string,
  input  wire logic          q_full,
  output logic               in_stall,
  output logic               push,
  output g6d_pkg::cmd_t      cmd
);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    cmd.grp = 6'(in_char_code - g6d_pkg::BIAS);
    cmd.eol = (in_char_code == g6d_pkg::CHAR_LF) || (in_char_code == g6d_pkg::CHAR_NUL);
    if (!in_starts_string) begin
      cmd.cls = g6d_pkg::CLS_CONT;
    end else if (in_char_code == g6d_pkg::CHAR_SPARSE) begin
      cmd.cls = g6d_pkg::CLS_START_S6;
    end else if (in_char_code == g6d_pkg::CHAR_DIGRAPH) begin
      cmd.cls = g6d_pkg::CLS_START_D6;
    end else begin
      cmd.cls = g6d_pkg::CLS_START_G6;
    end
  end

endmodule
`default_nettype wire

/* hdl/g6d_queue.sv */
`default_nettype none
module g6d_queue #(
  parameter int DEPTH = g6d_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire g6d_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output logic               full,
  output g6d_pkg::q2b_t      head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  g6d_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.cmd   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_r + 1'b1);
    end
    if (push && !do_pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (!push && do_pop) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

/* hdl/g6d_back.sv */
`default_nettype none
module g6d_back #(
  parameter int MAX_VERTICES = g6d_pkg::MAX_VERTICES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire g6d_pkg::q2b_t head,
  output logic               pop,
  input  wire logic          out_stall,
  output logic               out_valid,
  output logic [9:0]         out_first_vertex,
  output logic [9:0]         out_second_vertex,
  output logic               out_size_error,
  output logic               out_last_of_run
);

  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int IBW = $clog2(NW + 1);
  localparam int VW = g6d_pkg::VERTEX_W;
  localparam int CNTW = g6d_pkg::COUNT_W;
  localparam logic [CNTW-1:0] VC_MAX = CNTW'(MAX_VERTICES);

  // decoder state
  g6d_pkg::fmt_t   fmt_r, fmt_nxt;
  logic [3:0]      hbl_r, hbl_nxt;
  logic [CNTW-1:0] vc_r, vc_nxt;
  logic [NW-1:0]   row_r, row_nxt;
  logic [NW-1:0]   col_r, col_nxt;
  logic [IBW-1:0]  ib_r, ib_nxt;
  logic [NW-1:0]   cv_r, cv_nxt;
  logic [NW-1:0]   pi_r, pi_nxt;
  logic [IBW-1:0]  bsn_r, bsn_nxt;
  logic            inrec_r, inrec_nxt;
  logic            done_r, done_nxt;
  logic [2:0]      bit_r, bit_nxt;

  // held result and output register
  logic            pend_v_r, pend_v_nxt;
  logic            pend_f_r, pend_f_nxt;
  logic [VW-1:0]   pend_a_r, pend_a_nxt;
  logic [VW-1:0]   pend_b_r, pend_b_nxt;
  logic            pend_e_r, pend_e_nxt;
  logic            out_valid_r;
  logic [VW-1:0]   out_a_r;
  logic [VW-1:0]   out_b_r;
  logic            out_e_r;
  logic            out_l_r;

  // step signals
  logic            can_push, step_en, flush;
  logic            emit_v, emit_e, fin;
  logic [NW-1:0]   emit_a, emit_b;
  logic            hdr_go, body_go, fin_hdr, close_go;
  logic [3:0]      hdr_cnt;
  logic [CNTW-1:0] hdr_vc;
  logic [NW-1:0]   n, n_hdr, nm1, row_inc, col_inc, cv_t, pi_t;
  logic [IBW-1:0]  blen;
  logic            bit_val;
  logic            push;
  logic [VW-1:0]   push_a, push_b;
  logic            push_e, push_l;

  assign can_push = !out_valid_r || !out_stall;
  assign flush    = pend_v_r && pend_f_r && can_push;
  assign step_en  = head.valid && !(pend_v_r && pend_f_r) && can_push;
  assign pop      = step_en && fin;
  assign n        = vc_r[NW-1:0];
  assign bit_val  = head.cmd.grp[bit_r];

  // bit length of n-1 for sparse6 index records
  always_comb begin
    nm1  = NW'(n_hdr - 1'b1);
    blen = '0;
    for (int k = 0; k < NW; k++) begin
      if (nm1[k]) begin
        blen = IBW'(k + 1);
      end
    end
  end

  always_comb begin
    fmt_nxt   = fmt_r;
    hbl_nxt   = hbl_r;
    vc_nxt    = vc_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    ib_nxt    = ib_r;
    cv_nxt    = cv_r;
    pi_nxt    = pi_r;
    bsn_nxt   = bsn_r;
    inrec_nxt = inrec_r;
    done_nxt  = done_r;
    bit_nxt   = bit_r;
    emit_v    = 1'b0;
    emit_e    = 1'b0;
    emit_a    = '0;
    emit_b    = '0;
    fin       = 1'b1;
    hdr_go    = 1'b0;
    body_go   = 1'b0;
    fin_hdr   = 1'b0;
    close_go  = 1'b0;
    hdr_cnt   = hbl_r;
    hdr_vc    = vc_r;
    n_hdr     = '0;
    row_inc   = '0;
    col_inc   = '0;
    cv_t      = cv_r;
    pi_t      = pi_r;

    if (step_en) begin
      if (head.cmd.cls != g6d_pkg::CLS_CONT) begin
        // new string: clear everything
        done_nxt  = 1'b0;
        hbl_nxt   = g6d_pkg::HDR_FIRST;
        vc_nxt    = '0;
        row_nxt   = '0;
        col_nxt   = '0;
        ib_nxt    = '0;
        cv_nxt    = '0;
        pi_nxt    = '0;
        bsn_nxt   = '0;
        inrec_nxt = 1'b0;
      end
      case (head.cmd.cls)
        g6d_pkg::CLS_START_S6: begin
          fmt_nxt = g6d_pkg::FMT_S6;
        end
        g6d_pkg::CLS_START_D6: begin
          fmt_nxt = g6d_pkg::FMT_D6;
        end
        g6d_pkg::CLS_START_G6: begin
          fmt_nxt = g6d_pkg::FMT_G6;
          hdr_go  = 1'b1;
          hdr_cnt = g6d_pkg::HDR_FIRST;
          hdr_vc  = '0;
        end
        g6d_pkg::CLS_CONT: begin
          if (!done_r) begin
            if (hbl_r != g6d_pkg::HDR_BODY) begin
              hdr_go = 1'b1;
            end else if (fmt_r == g6d_pkg::FMT_S6 && head.cmd.eol) begin
              done_nxt = 1'b1;
            end else begin
              body_go = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    // size header byte
    if (hdr_go) begin
      if (hdr_cnt == g6d_pkg::HDR_FIRST) begin
        if (head.cmd.grp != g6d_pkg::ESCAPE) begin
          vc_nxt  = CNTW'(head.cmd.grp);
          fin_hdr = 1'b1;
        end else begin
          hbl_nxt = g6d_pkg::HDR_ESC;
        end
      end else if (hdr_cnt == g6d_pkg::HDR_ESC) begin
        if (head.cmd.grp != g6d_pkg::ESCAPE) begin
          vc_nxt  = CNTW'(head.cmd.grp);
          hbl_nxt = g6d_pkg::HDR_SHORT;
        end else begin
          vc_nxt  = '0;
          hbl_nxt = g6d_pkg::HDR_LONG;
        end
      end else begin
        vc_nxt  = {hdr_vc[CNTW-7:0], head.cmd.grp};
        hbl_nxt = 4'(hdr_cnt - 1'b1);
        fin_hdr = (hbl_nxt == g6d_pkg::HDR_BODY);
      end
      if (fin_hdr) begin
        hbl_nxt = g6d_pkg::HDR_BODY;
        if (vc_nxt > VC_MAX) begin
          emit_v   = 1'b1;
          emit_e   = 1'b1;
          done_nxt = 1'b1;
        end else begin
          n_hdr = vc_nxt[NW-1:0];
          if (n_hdr == '0) begin
            done_nxt = 1'b1;
          end else begin
            row_nxt = '0;
            case (fmt_nxt)
              g6d_pkg::FMT_G6: begin
                col_nxt = NW'(1);
                if (n_hdr < NW'(2)) begin
                  done_nxt = 1'b1;
                end
              end
              g6d_pkg::FMT_D6: begin
                col_nxt = '0;
              end
              g6d_pkg::FMT_S6: begin
                col_nxt   = '0;
                ib_nxt    = blen;
                cv_nxt    = '0;
                pi_nxt    = '0;
                bsn_nxt   = '0;
                inrec_nxt = 1'b0;
              end
              default: ;
            endcase
          end
        end
      end
    end

    // one body bit per step, most significant first
    if (body_go) begin
      case (fmt_r)
        g6d_pkg::FMT_G6: begin
          if (bit_val) begin
            emit_v = 1'b1;
            emit_a = row_r;
            emit_b = col_r;
          end
          row_inc = NW'(row_r + 1'b1);
          if (row_inc >= col_r) begin
            row_nxt = '0;
            col_inc = NW'(col_r + 1'b1);
            col_nxt = col_inc;
            if (col_inc >= n) begin
              done_nxt = 1'b1;
            end
          end else begin
            row_nxt = row_inc;
          end
        end
        g6d_pkg::FMT_D6: begin
          if (bit_val) begin
            emit_v = 1'b1;
            emit_a = row_r;
            emit_b = col_r;
          end
          col_inc = NW'(col_r + 1'b1);
          if (col_inc >= n) begin
            col_nxt = '0;
            row_inc = NW'(row_r + 1'b1);
            row_nxt = row_inc;
            if (row_inc >= n) begin
              done_nxt = 1'b1;
            end
          end else begin
            col_nxt = col_inc;
          end
        end
        g6d_pkg::FMT_S6: begin
          if (!inrec_r) begin
            // b bit of a record
            if (bit_val && cv_r < n) begin
              cv_t = NW'(cv_r + 1'b1);
            end
            cv_nxt    = cv_t;
            pi_t      = '0;
            pi_nxt    = '0;
            bsn_nxt   = ib_r;
            inrec_nxt = 1'b1;
            close_go  = (ib_r == '0);
          end else begin
            pi_t     = NW'({pi_r, bit_val});
            pi_nxt   = pi_t;
            bsn_nxt  = IBW'(bsn_r - 1'b1);
            close_go = (bsn_nxt == '0);
          end
          if (close_go) begin
            inrec_nxt = 1'b0;
            if (pi_t > cv_t) begin
              cv_nxt = pi_t;
            end else if (cv_t < n) begin
              emit_v = 1'b1;
              emit_a = cv_t;
              emit_b = pi_t;
            end
          end
        end
        default: ;
      endcase
      fin = (bit_r == '0) || done_nxt;
    end

    if (step_en) begin
      bit_nxt = fin ? g6d_pkg::BIT_TOP : 3'(bit_r - 1'b1);
    end
  end

  // last-of-run tagging: hold one result until the next one or the end of the word
  always_comb begin
    pend_v_nxt = pend_v_r;
    pend_f_nxt = pend_f_r;
    pend_a_nxt = pend_a_r;
    pend_b_nxt = pend_b_r;
    pend_e_nxt = pend_e_r;
    push       = 1'b0;
    push_a     = pend_a_r;
    push_b     = pend_b_r;
    push_e     = pend_e_r;
    push_l     = 1'b1;
    if (flush) begin
      push       = 1'b1;
      pend_v_nxt = 1'b0;
      pend_f_nxt = 1'b0;
    end else if (step_en) begin
      if (emit_v && pend_v_r) begin
        push       = 1'b1;
        push_l     = 1'b0;
        pend_a_nxt = VW'(emit_a);
        pend_b_nxt = VW'(emit_b);
        pend_e_nxt = emit_e;
        pend_f_nxt = fin;
      end else if (emit_v) begin
        if (fin) begin
          push   = 1'b1;
          push_a = VW'(emit_a);
          push_b = VW'(emit_b);
          push_e = emit_e;
        end else begin
          pend_v_nxt = 1'b1;
          pend_f_nxt = 1'b0;
          pend_a_nxt = VW'(emit_a);
          pend_b_nxt = VW'(emit_b);
          pend_e_nxt = emit_e;
        end
      end else if (fin && pend_v_r) begin
        push       = 1'b1;
        pend_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= g6d_pkg::FMT_G6;
      hbl_r       <= g6d_pkg::HDR_BODY;
      vc_r        <= '0;
      row_r       <= '0;
      col_r       <= '0;
      ib_r        <= '0;
      cv_r        <= '0;
      pi_r        <= '0;
      bsn_r       <= '0;
      inrec_r     <= 1'b0;
      done_r      <= 1'b1;
      bit_r       <= g6d_pkg::BIT_TOP;
      pend_v_r    <= 1'b0;
      pend_f_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fmt_r       <= fmt_nxt;
      hbl_r       <= hbl_nxt;
      vc_r        <= vc_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      ib_r        <= ib_nxt;
      cv_r        <= cv_nxt;
      pi_r        <= pi_nxt;
      bsn_r       <= bsn_nxt;
      inrec_r     <= inrec_nxt;
      done_r      <= done_nxt;
      bit_r       <= bit_nxt;
      pend_v_r    <= pend_v_nxt;
      pend_f_r    <= pend_f_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_a_r <= pend_a_nxt;
    pend_b_r <= pend_b_nxt;
    pend_e_r <= pend_e_nxt;
    if (push) begin
      out_a_r <= push_a;
      out_b_r <= push_b;
      out_e_r <= push_e;
      out_l_r <= push_l;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_first_vertex  = out_a_r;
  assign out_second_vertex = out_b_r;
  assign out_size_error    = out_e_r;
  assign out_last_of_run   = out_l_r;

endmodule
`default_nettype wire

/* hdl/g6d_checker.sv */
`default_nettype none
module g6d_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [9:0] out_first_vertex,
  input wire logic [9:0] out_second_vertex,
  input wire logic       out_size_error,
  input wire logic       out_last_of_run
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_first_vertex)
      && $stable(out_second_vertex) && $stable(out_size_error) && $stable(out_last_of_run))
    else $error("stalled result word changed");

  // size error is a lone result with zero vertices
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_size_error |-> out_first_vertex == '0 && out_second_vertex == '0
      && out_last_of_run)
    else $error("size error word malformed");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // reset empties the queue
  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind graph6_string_edge_decoder_unit g6d_checker u_g6d_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_first_vertex  (out_first_vertex),
  .out_second_vertex (out_second_vertex),
  .out_size_error    (out_size_error),
  .out_last_of_run   (out_last_of_run)
);
`default_nettype wire

/* bench/edge_word_checker.sv */
`timescale 1ns / 100ps
module edge_word_checker #(
  parameter int MAX_VERTICES = g6d_pkg::MAX_VERTICES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_starts_string,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [9:0] out_first_vertex,
  input  logic [9:0] out_second_vertex,
  input  logic       out_size_error,
  input  logic       out_last_of_run,
  output int         fail_count,
  output int         open_count
);

  typedef struct packed {
    logic [9:0] first_v;
    logic [9:0] second_v;
    logic       size_err;
    logic       run_end;
  } edge_word_t;

  // decoder state
  g6d_pkg::fmt_t fmt;
  logic [3:0]  hdr_left;
  logic [35:0] vcount;
  int unsigned row_i;
  int unsigned col_i;
  int unsigned idx_bits;
  int unsigned cur_v;
  int unsigned part_x;
  int unsigned bits_left;
  logic        in_index;
  logic        done;

  edge_word_t  char_edges[$];
  edge_word_t  pending_edges[$];
  edge_word_t  got;
  edge_word_t  want;

  function automatic void clear_decoder();
    fmt       = g6d_pkg::FMT_G6;
    hdr_left  = g6d_pkg::HDR_BODY;
    vcount    = '0;
    row_i     = 0;
    col_i     = 0;
    idx_bits  = 0;
    cur_v     = 0;
    part_x    = 0;
    bits_left = 0;
    in_index  = 1'b0;
    done      = 1'b1;
  endfunction

  function automatic void push_edge(int unsigned a, int unsigned b, logic err);
    edge_word_t w;
    if (char_edges.size() >= 6) return;
    w.first_v  = 10'(a);
    w.second_v = 10'(b);
    w.size_err = err;
    w.run_end  = 1'b0;
    char_edges.push_back(w);
  endfunction

  function automatic void close_header();
    int unsigned n;
    int unsigned t;
    hdr_left = g6d_pkg::HDR_BODY;
    if (vcount > MAX_VERTICES) begin
      push_edge(0, 0, 1'b1);
      done = 1'b1;
      return;
    end
    n = vcount[31:0];
    if (n == 0) begin
      done = 1'b1;
      return;
    end
    row_i = 0;
    case (fmt)
      g6d_pkg::FMT_G6: begin
        col_i = 1;
        if (n < 2) done = 1'b1;
      end
      g6d_pkg::FMT_D6: col_i = 0;
      default: begin
        col_i    = 0;
        idx_bits = 0;
        for (t = n - 1; t != 0; t >>= 1) idx_bits++;
        cur_v     = 0;
        part_x    = 0;
        bits_left = 0;
        in_index  = 1'b0;
      end
    endcase
  endfunction

  function automatic void take_size(logic [5:0] g);
    if (hdr_left == g6d_pkg::HDR_FIRST) begin
      if (g != g6d_pkg::ESCAPE) begin
        vcount = 36'(g);
        close_header();
      end else begin
        hdr_left = g6d_pkg::HDR_ESC;
      end
    end else if (hdr_left == g6d_pkg::HDR_ESC) begin
      if (g != g6d_pkg::ESCAPE) begin
        vcount   = 36'(g);
        hdr_left = g6d_pkg::HDR_SHORT;
      end else begin
        vcount   = '0;
        hdr_left = g6d_pkg::HDR_LONG;
      end
    end else begin
      vcount   = {vcount[29:0], g};
      hdr_left = hdr_left - 4'd1;
      if (hdr_left == g6d_pkg::HDR_BODY) close_header();
    end
  endfunction

  // end of a sparse record: jump ahead or emit
  function automatic void close_record();
    int unsigned n;
    n        = vcount[31:0];
    in_index = 1'b0;
    if (part_x > cur_v) cur_v = part_x;
    else if (cur_v < n) push_edge(cur_v, part_x, 1'b0);
  endfunction

  function automatic void take_bit(logic b_in);
    int unsigned n;
    n = vcount[31:0];
    if (done) return;
    case (fmt)
      g6d_pkg::FMT_G6: begin
        if (b_in) push_edge(row_i, col_i, 1'b0);
        row_i++;
        if (row_i >= col_i) begin
          row_i = 0;
          col_i++;
          if (col_i >= n) done = 1'b1;
        end
      end
      g6d_pkg::FMT_D6: begin
        if (b_in) push_edge(row_i, col_i, 1'b0);
        col_i++;
        if (col_i >= n) begin
          col_i = 0;
          row_i++;
          if (row_i >= n) done = 1'b1;
        end
      end
      default: begin
        if (!in_index) begin
          if (b_in && cur_v < n) cur_v++;
          part_x    = 0;
          bits_left = idx_bits;
          in_index  = 1'b1;
          if (bits_left == 0) close_record();
        end else begin
          part_x = (part_x << 1) | b_in;
          bits_left--;
          if (bits_left == 0) close_record();
        end
      end
    endcase
  endfunction

  function automatic void take_char(logic [7:0] c);
    logic [7:0] diff;
    int         k;
    diff = c - g6d_pkg::BIAS;
    if (hdr_left != g6d_pkg::HDR_BODY) begin
      take_size(diff[5:0]);
      return;
    end
    if (fmt == g6d_pkg::FMT_S6 && (c == g6d_pkg::CHAR_LF || c == g6d_pkg::CHAR_NUL)) begin
      done = 1'b1;
      return;
    end
    for (k = 5; k >= 0; k--) take_bit(diff[k]);
  endfunction

  // edge words that one character causes
  function automatic void decode_char(logic [7:0] c, logic st);
    edge_word_t w;
    char_edges.delete();
    if (st) begin
      clear_decoder();
      done     = 1'b0;
      hdr_left = g6d_pkg::HDR_FIRST;
      if (c == g6d_pkg::CHAR_SPARSE) fmt = g6d_pkg::FMT_S6;
      else if (c == g6d_pkg::CHAR_DIGRAPH) fmt = g6d_pkg::FMT_D6;
      else begin
        fmt = g6d_pkg::FMT_G6;
        take_char(c);
      end
    end else if (!done) begin
      take_char(c);
    end
    if (char_edges.size() != 0) begin
      w = char_edges.pop_back();
      w.run_end = 1'b1;
      char_edges.push_back(w);
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $time, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    open_count = 0;
    clear_decoder();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_decoder();
      pending_edges.delete();
    end else begin
      if (in_valid && !in_stall) begin
        decode_char(in_char_code, in_starts_string);
        foreach (char_edges[i]) pending_edges.push_back(char_edges[i]);
      end
      if (out_valid && !out_stall) begin
        got = {out_first_vertex, out_second_vertex, out_size_error, out_last_of_run};
        if (pending_edges.size() == 0) begin
          report_mismatch($sformatf("unexpected edge word (%0d,%0d) err %0b last %0b",
                                    got.first_v, got.second_v, got.size_err, got.run_end));
        end else begin
          want = pending_edges.pop_front();
          if (got !== want)
            report_mismatch($sformatf(
              "edge word (%0d,%0d) err %0b last %0b, wanted (%0d,%0d) err %0b last %0b",
              got.first_v, got.second_v, got.size_err, got.run_end,
              want.first_v, want.second_v, want.size_err, want.run_end));
        end
      end
    end
    open_count = pending_edges.size();
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
module testbench;

  // how a vertex count is written in the size header
  typedef enum int {
    SIZE_1B,
    SIZE_4B,
    SIZE_8B
  } size_form_t;

  localparam int MAX_N = g6d_pkg::MAX_VERTICES_DEF;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_code;
  logic       in_starts_string;
  logic       out_valid;
  logic       out_stall;
  logic [9:0] out_first_vertex;
  logic [9:0] out_second_vertex;
  logic       out_size_error;
  logic       out_last_of_run;

  int   fail_count;
  int   open_count;
  int   sent;
  logic calm;  // no idling on either side while set

  graph6_string_edge_decoder_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_code      (in_char_code),
    .in_starts_string  (in_starts_string),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_first_vertex  (out_first_vertex),
    .out_second_vertex (out_second_vertex),
    .out_size_error    (out_size_error),
    .out_last_of_run   (out_last_of_run)
  );

  // predicts edge words from accepted characters and compares them
  edge_word_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_code      (in_char_code),
    .in_starts_string  (in_starts_string),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_first_vertex  (out_first_vertex),
    .out_second_vertex (out_second_vertex),
    .out_size_error    (out_size_error),
    .out_last_of_run   (out_last_of_run),
    .fail_count        (fail_count),
    .open_count        (open_count)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // idle cycles before a word, drawn at random; none while calm is set
  function automatic int draw_wait();
    if (calm) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 18);
    return $urandom_range(0, 2);
  endfunction

  // character that carries one six-bit group
  function automatic logic [7:0] grp_char(logic [5:0] g);
    return g6d_pkg::BIAS + {2'b00, g};
  endfunction

  // mostly printable groups, sometimes any byte (wraps mod 64)
  function automatic logic [7:0] body_char();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return grp_char(6'($urandom_range(0, 63)));
  endfunction

  // one character word; valid stays high into the next word when no gap is drawn
  task automatic send_char(input logic [7:0] c, input logic st);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_char_code     <= c;
    in_starts_string <= st;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // size header: one byte, escape plus three, or two escapes plus six
  task automatic send_count(input logic [35:0] n, input size_form_t form, input logic st);
    int k;
    if (form == SIZE_1B) begin
      send_char(grp_char(n[5:0]), st);
    end else begin
      send_char(grp_char(g6d_pkg::ESCAPE), st);
      if (form == SIZE_8B) begin
        send_char(grp_char(g6d_pkg::ESCAPE), 1'b0);
        for (k = 5; k >= 0; k--) send_char(grp_char(n[6*k +: 6]), 1'b0);
      end else begin
        for (k = 2; k >= 0; k--) send_char(grp_char(n[6*k +: 6]), 1'b0);
      end
    end
  endtask

  // result side: a fresh stall draw after every accepted edge word
  initial begin : result_drain
    int hold;
    out_stall <= 1'b0;
    forever begin
      do @(posedge clk); while (!out_valid || out_stall);
      hold = draw_wait();
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int         kind;
    int         n;
    int         len;
    logic       trunc;
    size_form_t form;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_char_code     <= '0;
    in_starts_string <= 1'b0;
    sent = 0;
    calm = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // stray character while idle, ignored
    send_char(grp_char(6'd2), 1'b0);
    // count zero: nothing at all
    send_count(36'd0, SIZE_1B, 1'b1);
    // graph6 with 4 vertices, one full group gives an edge for every vertex pair
    send_count(36'd4, SIZE_1B, 1'b1);
    send_char(grp_char(6'd63), 1'b0);
    // digraph6 with 3 vertices; the first body byte wraps to a full group
    send_char(g6d_pkg::CHAR_DIGRAPH, 1'b1);
    send_count(36'd3, SIZE_1B, 1'b0);
    send_char(8'h3E, 1'b0);
    send_char(grp_char(6'd63), 1'b0);
    // sparse6 with 2 vertices: the vertex runs past the end, then line feed ends it
    send_char(g6d_pkg::CHAR_SPARSE, 1'b1);
    send_count(36'd2, SIZE_1B, 1'b0);
    send_char(grp_char(6'd63), 1'b0);
    send_char(g6d_pkg::CHAR_LF, 1'b0);
    send_char(grp_char(6'd7), 1'b0);
    // four-byte count above the limit gives one error word
    send_count(36'd4096, SIZE_4B, 1'b1);
    // restart after an eight-vertex header with the largest eight-byte count
    send_count(36'd8, SIZE_1B, 1'b1);
    send_count(36'hF_FFFF_FFFF, SIZE_8B, 1'b1);

    // random strings, mostly well formed
    while (sent < 170) begin
      kind  = $urandom_range(0, 9);
      calm  = ($urandom_range(0, 3) == 0);
      form  = ($urandom_range(0, 4) == 0) ? size_form_t'($urandom_range(1, 2)) : SIZE_1B;
      trunc = ($urandom_range(0, 7) == 0);
      if (kind <= 3) begin
        // graph6: small sizes keep the upper triangle short
        n = $urandom_range(0, 14);
        send_count(36'(n), form, 1'b1);
        len = (n * (n - 1) / 2 + 5) / 6;
        if (trunc) len = $urandom_range(0, len);
        repeat (len) send_char(body_char(), 1'b0);
        repeat ($urandom_range(0, 2)) send_char(body_char(), 1'b0);
      end else if (kind <= 5) begin
        // digraph6
        n = $urandom_range(0, 8);
        send_char(g6d_pkg::CHAR_DIGRAPH, 1'b1);
        send_count(36'(n), form, 1'b0);
        len = (n * n + 5) / 6;
        if (trunc) len = $urandom_range(0, len);
        repeat (len) send_char(body_char(), 1'b0);
        repeat ($urandom_range(0, 2)) send_char(body_char(), 1'b0);
      end else if (kind <= 8) begin
        // sparse6: wide indexes are cheap here, so large counts too
        if ($urandom_range(0, 3) == 0)
          n = ($urandom_range(0, 2) == 0) ? MAX_N : $urandom_range(63, MAX_N);
        else
          n = $urandom_range(0, 40);
        if (n > 62 && form == SIZE_1B) form = SIZE_4B;
        send_char(g6d_pkg::CHAR_SPARSE, 1'b1);
        send_count(36'(n), form, 1'b0);
        repeat ($urandom_range(1, 10)) send_char(body_char(), 1'b0);
        if (!trunc)
          send_char(($urandom_range(0, 1) != 0) ? g6d_pkg::CHAR_LF : g6d_pkg::CHAR_NUL, 1'b0);
      end else begin
        // noise: oversize headers or arbitrary bytes with a rare start flag
        case ($urandom_range(0, 2))
          0: send_count(36'($urandom_range(MAX_N + 1, 262143)), SIZE_4B, 1'b1);
          1: send_count({4'($urandom()), 32'($urandom())}, SIZE_8B, 1'b1);
          default: repeat ($urandom_range(1, 4))
            send_char(8'($urandom_range(0, 255)), ($urandom_range(0, 5) == 0));
        endcase
      end
    end

    // drain: all expected words, then the tail of the block's pipeline
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* sim.f */
hdl/g6d_pkg.sv
hdl/g6d_front.sv
hdl/g6d_queue.sv
hdl/g6d_back.sv
hdl/graph6_string_edge_decoder_unit.sv
hdl/g6d_checker.sv
bench/edge_word_checker.sv
bench/testbench.sv
